@@ design/srrb_pkg.sv @@
package srrb_pkg;

	localparam int SLOT_W  = 7;
	localparam int COUNT_W = 8;

	typedef enum logic [1:0] {
		OP_WRITE       = 2'd0,
		OP_POP         = 2'd1,
		OP_READ_SLOT   = 2'd2,
		OP_READ_OLDEST = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_RANGE     = 2'd2,
		ST_NO_UNREAD = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		REG_TEMP_LEVEL  = 1'b0,
		REG_LIGHT_LEVEL = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [7:0] temperature;
		logic [7:0] luminosity;
	} record_t;

	// decoded request from the pointer logic
	typedef struct packed {
		status_t status;
		logic    is_write;
		logic    mem_we;
		logic    mem_re;
	} issue_t;

endpackage

@@ design/srrb_mem.sv @@
module srrb_mem #(
	parameter int DEPTH  = 128,
	parameter int ADDR_W = 7
) (
	input  logic                clk,
	input  logic                we,
	input  logic                re,
	input  logic [ADDR_W-1:0]   addr,
	input  srrb_pkg::record_t   wdata,
	output srrb_pkg::record_t   rdata
);
	import srrb_pkg::*;

	record_t mem_q [DEPTH];
	record_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/srrb_ctrl.sv @@
module srrb_ctrl #(
	parameter int DEPTH = 128,
	parameter int PTR_W = 7,
	parameter int CNT_W = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  srrb_pkg::op_t                 op,
	input  logic [srrb_pkg::SLOT_W-1:0]   k,
	output logic [PTR_W-1:0]              addr,
	output srrb_pkg::issue_t              issue,
	output logic [CNT_W-1:0]              fill
);
	import srrb_pkg::*;

	localparam int SUM_W = ((PTR_W > SLOT_W) ? PTR_W : SLOT_W) + 1;

	logic [PTR_W-1:0] wr_ptr_q, un_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic [PTR_W-1:0] wr_d, un_d, wr_next, un_next, oldest, kth;
	logic [CNT_W-1:0] fill_d;
	logic [SUM_W-1:0] sum;
	logic             k_oor, empty;

	assign wr_next = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
	assign un_next = (un_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : un_ptr_q + 1'b1;
	// oldest record is at the write pointer once the store has wrapped
	assign oldest  = (fill_q == CNT_W'(DEPTH)) ? wr_ptr_q : '0;
	assign sum     = SUM_W'(oldest) + SUM_W'(k);
	assign kth     = (sum >= SUM_W'(DEPTH)) ? PTR_W'(sum - SUM_W'(DEPTH)) : PTR_W'(sum);
	assign k_oor   = SUM_W'(k) >= SUM_W'(fill_q);
	assign empty   = (fill_q == '0);

	always_comb begin
		addr           = wr_ptr_q;
		issue.status   = ST_OK;
		issue.is_write = 1'b0;
		issue.mem_we   = 1'b0;
		issue.mem_re   = 1'b0;
		wr_d           = wr_ptr_q;
		un_d           = un_ptr_q;
		fill_d         = fill_q;
		case (op)
			OP_WRITE: begin
				issue.is_write = 1'b1;
				issue.mem_we   = 1'b1;
				wr_d           = wr_next;
				// overwrite drops the oldest unread record
				if (wr_next == un_ptr_q && !empty) begin
					un_d = un_next;
				end
				if (fill_q != CNT_W'(DEPTH)) begin
					fill_d = fill_q + 1'b1;
				end
			end
			OP_POP: begin
				if (empty) begin
					issue.status = ST_EMPTY;
				end else if (un_ptr_q == wr_ptr_q) begin
					issue.status = ST_NO_UNREAD;
				end else begin
					addr         = un_ptr_q;
					issue.mem_re = 1'b1;
					un_d         = un_next;
				end
			end
			OP_READ_SLOT: begin
				if (empty) begin
					issue.status = ST_EMPTY;
				end else if (k_oor) begin
					issue.status = ST_RANGE;
				end else begin
					addr         = PTR_W'(k);
					issue.mem_re = 1'b1;
				end
			end
			OP_READ_OLDEST: begin
				if (empty) begin
					issue.status = ST_EMPTY;
				end else if (k_oor) begin
					issue.status = ST_RANGE;
				end else begin
					addr         = kth;
					issue.mem_re = 1'b1;
				end
			end
			default: begin
				issue.status = ST_EMPTY;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			un_ptr_q <= '0;
			fill_q   <= '0;
		end else if (accept) begin
			wr_ptr_q <= wr_d;
			un_ptr_q <= un_d;
			fill_q   <= fill_d;
		end
	end

	assign fill = fill_q;

endmodule

@@ design/sensor_record_ring_buffer_unit.sv @@
// An accepted request shows its result (out_valid) in the next cycle.
// Throughput: one request per cycle while out_stall stays low; the single record
// memory port and its registered read set this figure.
// Reset (arst_n low): write/unread pointers and fill count clear to zero, the
// temperature level goes to 255 and the luminosity level to 0; the record memory is not cleared.
module sensor_record_ring_buffer_unit #(
	parameter int DEPTH = 128
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [0:0]                        cfg_index,
	input  logic [7:0]                        cfg_data,
	// request channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        op,
	input  logic [srrb_pkg::SLOT_W-1:0]       slot_index,
	input  logic [4:0]                        in_hour,
	input  logic [5:0]                        in_minute,
	input  logic [5:0]                        in_second,
	input  logic [7:0]                        in_temperature,
	input  logic [7:0]                        in_luminosity,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        status,
	output logic [srrb_pkg::SLOT_W-1:0]       out_slot,
	output logic [4:0]                        out_hour,
	output logic [5:0]                        out_minute,
	output logic [5:0]                        out_second,
	output logic [7:0]                        out_temperature,
	output logic [7:0]                        out_luminosity,
	output logic                              alarm,
	output logic [srrb_pkg::COUNT_W-1:0]      stored_count
);
	import srrb_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	// alarm thresholds
	logic [7:0] temp_level_q, light_level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_level_q  <= 8'hFF;
			light_level_q <= 8'h00;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TEMP_LEVEL:  temp_level_q  <= cfg_data;
				REG_LIGHT_LEVEL: light_level_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Request side. A result held in stage 1 under out_stall blocks the next
	// request; otherwise the pipe takes one request per cycle.
	logic             in_accept;
	logic             valid_s1;
	logic [PTR_W-1:0] addr;
	issue_t           issue;
	logic [CNT_W-1:0] fill;
	record_t          in_rec, rd_rec, res_rec;

	assign in_stall  = valid_s1 && out_stall;
	assign in_accept = in_valid && !in_stall;

	assign in_rec.hour        = in_hour;
	assign in_rec.minute      = in_minute;
	assign in_rec.second      = in_second;
	assign in_rec.temperature = in_temperature;
	assign in_rec.luminosity  = in_luminosity;

	// pointers, fill count and status decode
	srrb_ctrl #(
		.DEPTH (DEPTH),
		.PTR_W (PTR_W),
		.CNT_W (CNT_W)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (in_accept),
		.op     (op_t'(op)),
		.k      (slot_index),
		.addr   (addr),
		.issue  (issue),
		.fill   (fill)
	);

	// record store; reads land in its output register in the next cycle. A write
	// and a read never share an edge, so a read right after a write to the
	// same slot already sees the new record.
	srrb_mem #(
		.DEPTH  (DEPTH),
		.ADDR_W (PTR_W)
	) u_mem (
		.clk   (clk),
		.we    (in_accept && issue.mem_we),
		.re    (in_accept && issue.mem_re),
		.addr  (addr),
		.wdata (in_rec),
		.rdata (rd_rec)
	);

	// stage 1: result bookkeeping next to the memory read register
	status_t          status_s1;
	logic             is_write_s1;
	logic [PTR_W-1:0] slot_s1;
	record_t          wrec_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (!out_stall) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			status_s1   <= issue.status;
			is_write_s1 <= issue.is_write;
			slot_s1     <= addr;
			wrec_s1     <= in_rec;
		end
	end

	// error results carry zero slot, record and alarm
	logic res_ok;

	assign res_ok  = (status_s1 == ST_OK);
	assign res_rec = !res_ok ? '0 : (is_write_s1 ? wrec_s1 : rd_rec);

	assign out_valid       = valid_s1;
	assign status          = status_s1;
	assign out_slot        = res_ok ? SLOT_W'(slot_s1) : '0;
	assign out_hour        = res_rec.hour;
	assign out_minute      = res_rec.minute;
	assign out_second      = res_rec.second;
	assign out_temperature = res_rec.temperature;
	assign out_luminosity  = res_rec.luminosity;
	assign alarm           = res_ok && (res_rec.temperature >= temp_level_q ||
	                                    res_rec.luminosity <= light_level_q);
	// fill only moves on accept, so it is the count after the held request
	assign stored_count    = COUNT_W'(fill);

	// a write always completes with an ok result
	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && op == OP_WRITE |=> out_valid && status == ST_OK)
		else $error("write request did not give an ok result");

	// reads on an empty store report empty
	a_empty_read: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && op != OP_WRITE && fill == '0 |=> status == ST_EMPTY)
		else $error("read of empty store not flagged");

	// error results carry no record
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> out_slot == '0 && alarm == 1'b0 &&
			out_temperature == '0 && out_hour == '0)
		else $error("error result carries record data");

	// fill count never passes the depth and never drops on an accepted request
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> fill <= CNT_W'(DEPTH) && fill >= $past(fill))
		else $error("fill count out of bounds");

endmodule
